// File: hw/rtl/rtphv_pkg.sv
// Shared types and constants for the RTP header validator.
package rtphv_pkg;

  localparam int MAX_PACKET_BYTES = 4096;
  localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
  // holds 12 + 4*15 + 4 + 4*65535 and any byte count
  localparam int WIDE_W           = (CNT_W > 19) ? CNT_W : 19;
  localparam int HS_W             = 7;
  localparam int FIXED_HDR        = 12;
  localparam int EXT_HDR          = 4;
  localparam logic [1:0] RTP_V2   = 2'd2;
  localparam int Q_DEPTH          = 4;
  localparam int Q_PTR_W          = $clog2(Q_DEPTH);
  localparam int OUT_W            = 40;
  localparam logic [6:0] AUDIO_PT_RST     = 7'd10;
  localparam logic [6:0] CONTAINER_PT_RST = 7'd123;

  typedef enum logic [0:0] {
    REG_AUDIO_PT     = 1'b0,
    REG_CONTAINER_PT = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_SHORT          = 4'd1,
    ST_BAD_VER        = 4'd2,
    ST_SHORT_EXT_HDR  = 4'd3,
    ST_SHORT_EXT_DATA = 4'd4,
    ST_PAD_EMPTY      = 4'd5,
    ST_PAD_ZERO       = 4'd6,
    ST_PAD_BIG        = 4'd7,
    ST_BAD_TYPE       = 4'd8
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic [7:0]       first_byte;
    logic [6:0]       type_byte;
    logic [15:0]      ext_words;
    logic [7:0]       pad_octet;
  } pkt_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0]  size;
    logic [HS_W-1:0]   hs_base;
    logic [WIDE_W-1:0] hs_full;
    logic [1:0]        version;
    logic              has_pad;
    logic [7:0]        pad_octet;
    logic [6:0]        type_byte;
  } hdr_calc_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_sts_t;

endpackage

// File: hw/rtl/rtphv_front.sv
// Byte front end: counts bytes, captures header fields, queues one record per packet.
module rtphv_front
  import rtphv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  input  q_sts_t     q_sts,
  output logic       q_push,
  output pkt_rec_t   q_rec
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [7:0]        fhb_r, fhb_nxt;
  logic [6:0]        typ_r, typ_nxt;
  logic [15:0]       ext_r, ext_nxt;
  logic [WIDE_W-1:0] pos_w, ext_at;
  logic              acc;

  assign in_tready = ~q_sts.full;
  assign acc       = in_tvalid & in_tready;
  assign pos_w     = WIDE_W'(cnt_r);
  assign ext_at    = WIDE_W'(FIXED_HDR + 2) + WIDE_W'({fhb_r[3:0], 2'b00});

  always_comb begin
    cnt_nxt = cnt_r;
    fhb_nxt = fhb_r;
    typ_nxt = typ_r;
    ext_nxt = ext_r;
    if (cnt_r < CNT_W'(MAX_PACKET_BYTES)) begin
      if (cnt_r == '0) fhb_nxt = in_tdata;
      if (cnt_r == CNT_W'(1)) typ_nxt = in_tdata[6:0];
      if (pos_w >= WIDE_W'(FIXED_HDR)) begin
        if (pos_w == ext_at) ext_nxt[15:8] = in_tdata;
        else if (pos_w == ext_at + WIDE_W'(1)) ext_nxt[7:0] = in_tdata;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    q_rec.size       = cnt_nxt;
    q_rec.first_byte = fhb_nxt;
    q_rec.type_byte  = typ_nxt;
    q_rec.ext_words  = ext_nxt;
    q_rec.pad_octet  = in_tdata;
    q_push           = acc & in_tlast;
    if (in_tlast) begin
      cnt_nxt = '0;
      fhb_nxt = '0;
      typ_nxt = '0;
      ext_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fhb_r <= '0;
      typ_r <= '0;
      ext_r <= '0;
    end else if (acc) begin
      cnt_r <= cnt_nxt;
      fhb_r <= fhb_nxt;
      typ_r <= typ_nxt;
      ext_r <= ext_nxt;
    end
  end

endmodule

// File: hw/rtl/rtphv_fifo.sv
// Short record queue between the front end and the verdict pipeline.
module rtphv_fifo
  import rtphv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  q_ctl_t   q_ctl,
  input  pkt_rec_t wr_data,
  output pkt_rec_t rd_data,
  output q_sts_t   q_sts
);

  pkt_rec_t           mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push, do_pop;

  assign q_sts.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign q_sts.empty = (cnt_r == '0);
  assign do_push     = q_ctl.push & ~q_sts.full;
  assign do_pop      = q_ctl.pop & ~q_sts.empty;
  assign rd_data     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (Q_PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (Q_PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/rtphv_back.sv
// Verdict pipeline: header size sums, then ordered checks into the output register.
module rtphv_back
  import rtphv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pkt_rec_t         rec,
  input  q_sts_t           q_sts,
  output logic             q_pop,
  input  logic [6:0]       audio_pt,
  input  logic [6:0]       container_pt,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tuser
);

  hdr_calc_t         s1_r, s1_nxt;
  logic              s1_v_r;
  logic              s1_en, s2_en;
  logic              out_v_r;
  status_t           st_r, st_nxt;
  logic [12:0]       off_r, off_nxt, len_r, len_nxt;
  logic              kind_r, kind_nxt;
  logic [6:0]        typ_r;
  logic [WIDE_W-1:0] size_w, plen_w;
  logic              has_ext;

  assign s2_en = ~out_v_r | out_tready;
  assign s1_en = ~s1_v_r | s2_en;
  assign q_pop = s1_en & ~q_sts.empty;

  // stage 1: header sizes
  always_comb begin
    has_ext          = rec.first_byte[4];
    s1_nxt.size      = rec.size;
    s1_nxt.version   = rec.first_byte[7:6];
    s1_nxt.has_pad   = rec.first_byte[5];
    s1_nxt.pad_octet = rec.pad_octet;
    s1_nxt.type_byte = rec.type_byte;
    s1_nxt.hs_base   = HS_W'(FIXED_HDR) + HS_W'({rec.first_byte[3:0], 2'b00})
                     + (has_ext ? HS_W'(EXT_HDR) : HS_W'(0));
    s1_nxt.hs_full   = WIDE_W'(s1_nxt.hs_base)
                     + (has_ext ? WIDE_W'({rec.ext_words, 2'b00}) : WIDE_W'(0));
  end

  // stage 2: ordered checks
  always_comb begin
    size_w   = WIDE_W'(s1_r.size);
    plen_w   = size_w - s1_r.hs_full;
    st_nxt   = ST_OK;
    kind_nxt = 1'b0;
    if (size_w < WIDE_W'(FIXED_HDR))                    st_nxt = ST_SHORT;
    else if (s1_r.version != RTP_V2)                    st_nxt = ST_BAD_VER;
    else if (size_w < WIDE_W'(s1_r.hs_base))            st_nxt = ST_SHORT_EXT_HDR;
    else if (size_w < s1_r.hs_full)                     st_nxt = ST_SHORT_EXT_DATA;
    else if (s1_r.has_pad && plen_w == '0)              st_nxt = ST_PAD_EMPTY;
    else if (s1_r.has_pad && s1_r.pad_octet == 8'd0)    st_nxt = ST_PAD_ZERO;
    else if (s1_r.has_pad && plen_w < WIDE_W'(s1_r.pad_octet)) st_nxt = ST_PAD_BIG;
    else if (s1_r.type_byte == container_pt)            kind_nxt = 1'b1;
    else if (s1_r.type_byte != audio_pt)                st_nxt = ST_BAD_TYPE;
    if (s1_r.has_pad) plen_w = plen_w - WIDE_W'(s1_r.pad_octet);
    if (st_nxt == ST_OK) begin
      off_nxt = s1_r.hs_full[12:0];
      len_nxt = plen_w[12:0];
    end else begin
      off_nxt  = '0;
      len_nxt  = '0;
      kind_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_en) s1_v_r  <= ~q_sts.empty;
      if (s2_en) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) s1_r <= s1_nxt;
    if (s2_en && s1_v_r) begin
      st_r   <= st_nxt;
      off_r  <= off_nxt;
      len_r  <= len_nxt;
      kind_r <= kind_nxt;
      typ_r  <= s1_r.type_byte;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'b000, typ_r, len_r, off_r, st_r};
  assign out_tuser  = kind_r;

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && st_r != ST_OK |-> off_r == '0 && len_r == '0 && !kind_r)
    else $error("failed verdict carries payload fields");

  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && st_r == ST_OK |-> off_r >= 13'(FIXED_HDR))
    else $error("payload start inside fixed header");

  a_ok_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && st_r == ST_OK |->
      (14'(off_r) + 14'(len_r)) <= 14'(MAX_PACKET_BYTES))
    else $error("payload runs past packet limit");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !s1_v_r || s2_en)
    else $error("pop into occupied stage");

endmodule

// File: hw/rtl/rtp_header_validator_unit.sv
// Top level of the RTP header validator: config registers, front end, queue, verdict pipeline.
//
// Usage:
//   in_*  : stream of packet bytes, one word per byte; in_tlast marks the last byte.
//   out_* : one verdict word per packet (status, payload start, payload length,
//           payload type; kind on out_tuser), produced once the last byte is taken.
//   cfg_* : APB write/read of the audio type (addr 0) and container type (addr 4).
// Throughput: one byte per cycle while the record queue is not full, sustained across
//   packet boundaries; back-to-back one-byte packets give one verdict per cycle while
//   out_tready stays high. The verdict is registered: the record is written to the queue
//   on the edge that takes the last byte, then passes the size sums and check stages.
// A 4-entry record queue decouples the byte front end from the verdict pipeline.
// Reset clears byte counters, queue and pipeline, and loads the payload type
//   registers with 10 (audio) and 123 (container).
// When the receiver stalls, the verdict holds in the output register, the pipeline
//   and queue fill, and in_tready drops only once the queue is full.
module rtp_header_validator_unit
  import rtphv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] data_byte
  input  logic             in_tlast,     // last_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  // [3:0] status, [16:4] payload_start, [29:17] payload_length,
  // [36:30] payload_type_seen, [39:37] zero
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tuser,    // [0] payload_kind
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [6:0] audio_pt_r, container_pt_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  q_ctl_t     q_ctl;
  q_sts_t     q_sts;
  logic       q_push, q_pop;
  pkt_rec_t   push_rec, head_rec;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign q_ctl      = '{push: q_push, pop: q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_pt_r     <= AUDIO_PT_RST;
      container_pt_r <= CONTAINER_PT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_AUDIO_PT:     audio_pt_r     <= cfg_pwdata[6:0];
        REG_CONTAINER_PT: container_pt_r <= cfg_pwdata[6:0];
        default:          audio_pt_r     <= audio_pt_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_AUDIO_PT:     cfg_prdata = {25'd0, audio_pt_r};
      REG_CONTAINER_PT: cfg_prdata = {25'd0, container_pt_r};
      default:          cfg_prdata = '0;
    endcase
  end

  rtphv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_sts     (q_sts),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  rtphv_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ctl   (q_ctl),
    .wr_data (push_rec),
    .rd_data (head_rec),
    .q_sts   (q_sts)
  );

  rtphv_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec          (head_rec),
    .q_sts        (q_sts),
    .q_pop        (q_pop),
    .audio_pt     (audio_pt_r),
    .container_pt (container_pt_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser)
  );

endmodule

// File: verif/rtp_header_validator_unit_test.sv
// Testbench for rtp_header_validator_unit: byte-stream RTP packets checked against a scoreboard.
`timescale 1ns / 100ps

module rtp_header_validator_unit_test;
  import rtphv_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    status_t     status;
    logic [12:0] offset;
    logic [12:0] length;
    logic        kind;
    logic [6:0]  ptype;
  } verdict_t;

  class rtp_verdict_board;
    logic [6:0]  audio_pt;
    logic [6:0]  container_pt;
    int          byte_cnt;
    logic [7:0]  hdr0;
    logic [6:0]  pt_byte;
    logic [15:0] ext_len;
    verdict_t    pending[$];
    int          errors;

    function new();
      audio_pt = AUDIO_PT_RST;
      container_pt = CONTAINER_PT_RST;
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_cnt = 0;
      hdr0 = '0;
      pt_byte = '0;
      ext_len = '0;
    endfunction

    function verdict_t verdict_of(logic [7:0] pad);
      verdict_t v;
      int hs;
      int plen;
      v = '0;
      v.ptype = pt_byte;
      hs = FIXED_HDR + 4 * int'(hdr0[3:0]);
      if (byte_cnt < FIXED_HDR) begin
        v.status = ST_SHORT;
      end else if (hdr0[7:6] != RTP_V2) begin
        v.status = ST_BAD_VER;
      end else begin
        if (hdr0[4]) hs += EXT_HDR;
        if (byte_cnt < hs) begin
          v.status = ST_SHORT_EXT_HDR;
        end else begin
          if (hdr0[4]) hs += 4 * int'(ext_len);
          if (byte_cnt < hs) begin
            v.status = ST_SHORT_EXT_DATA;
          end else begin
            plen = byte_cnt - hs;
            v.status = ST_OK;
            if (hdr0[5]) begin
              if (plen == 0) v.status = ST_PAD_EMPTY;
              else if (pad == 0) v.status = ST_PAD_ZERO;
              else if (plen < int'(pad)) v.status = ST_PAD_BIG;
              else plen -= int'(pad);
            end
            if (v.status == ST_OK) begin
              if (pt_byte == container_pt) v.kind = 1'b1;
              else if (pt_byte == audio_pt) v.kind = 1'b0;
              else v.status = ST_BAD_TYPE;
            end
            if (v.status == ST_OK) begin
              v.offset = hs[12:0];
              v.length = plen[12:0];
            end
          end
        end
      end
      return v;
    endfunction

    // one accepted input word
    function void take_byte(logic [7:0] b, logic last);
      int ext_at;
      if (byte_cnt < MAX_PACKET_BYTES) begin
        ext_at = FIXED_HDR + 4 * int'(hdr0[3:0]) + 2;
        if (byte_cnt == 0) hdr0 = b;
        else if (byte_cnt == 1) pt_byte = b[6:0];
        if (byte_cnt >= FIXED_HDR) begin
          if (byte_cnt == ext_at) ext_len[15:8] = b;
          else if (byte_cnt == ext_at + 1) ext_len[7:0] = b;
        end
        byte_cnt++;
      end
      if (last) begin
        pending.push_back(verdict_of(b));
        clear_packet();
      end
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_verdict(input logic [OUT_W-1:0] word, input logic user);
      verdict_t want;
      if (pending.size() == 0) begin
        report($sformatf("verdict %h with none pending", word));
      end else begin
        want = pending.pop_front();
        if (word[3:0] !== want.status)
          report($sformatf("status got %0d want %0d", word[3:0], want.status));
        if (word[16:4] !== want.offset)
          report($sformatf("offset got %0d want %0d", word[16:4], want.offset));
        if (word[29:17] !== want.length)
          report($sformatf("length got %0d want %0d", word[29:17], want.length));
        if (user !== want.kind)
          report($sformatf("kind got %0d want %0d", user, want.kind));
        if (word[36:30] !== want.ptype)
          report($sformatf("type got %0d want %0d", word[36:30], want.ptype));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [2:0]       cfg_paddr;
  logic [31:0]      cfg_pwdata;
  logic [31:0]      cfg_prdata;
  logic             cfg_pready;

  rtp_verdict_board sb;
  logic [7:0]       pkt[$];
  int               in_idle_pct;
  int               out_idle_pct;
  int               bytes_sent;
  int               packets_sent;
  int               stall_cycles;

  rtp_header_validator_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_verdict(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt[i]) begin
      send_byte(pkt[i], i == pkt.size() - 1);
      bytes_sent++;
    end
    packets_sent++;
  endtask

  // pad >= 0 overwrites the last byte with the pad octet
  task automatic build_packet(input logic [1:0] ver, input logic p, input logic x,
                              input logic [3:0] cc, input logic [6:0] pt,
                              input logic [15:0] elen, input int ebytes,
                              input int body, input int pad);
    pkt.delete();
    pkt.push_back({ver, p, x, cc});
    pkt.push_back({1'($urandom), pt});
    repeat (10 + 4 * int'(cc)) pkt.push_back(8'($urandom));
    if (x) begin
      repeat (2) pkt.push_back(8'($urandom));
      pkt.push_back(elen[15:8]);
      pkt.push_back(elen[7:0]);
      repeat (ebytes) pkt.push_back(8'($urandom));
    end
    repeat (body) pkt.push_back(8'($urandom));
    if (pad >= 0) pkt[pkt.size() - 1] = pad[7:0];
  endtask

  task automatic trim_packet(input int n);
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic make_random_packet();
    int          mode;
    int          r;
    int          body;
    int          pad;
    int          ebytes;
    logic [1:0]  ver;
    logic        p;
    logic        x;
    logic [3:0]  cc;
    logic [6:0]  pt;
    logic [15:0] elen;
    mode = $urandom_range(99);
    if (mode >= 90) begin
      pkt.delete();
      repeat ($urandom_range(30, 1)) pkt.push_back(8'($urandom));
    end else begin
      ver = (mode >= 82) ? 2'($urandom) : RTP_V2;
      p = ($urandom_range(3) == 0);
      x = ($urandom_range(2) == 0);
      cc = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2));
      elen = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      ebytes = (elen <= 3) ? 4 * int'(elen) : $urandom_range(16);
      if ($urandom_range(9) == 0) ebytes = $urandom_range(12);
      r = $urandom_range(9);
      pt = (r < 4) ? sb.audio_pt : (r < 8) ? sb.container_pt : 7'($urandom);
      body = p ? $urandom_range(24, 1) : $urandom_range(24);
      pad = -1;
      if (p) begin
        r = $urandom_range(9);
        pad = (r == 0) ? 0 : (r == 1) ? $urandom_range(255) : $urandom_range(body, 1);
      end
      build_packet(ver, p, x, cc, pt, elen, ebytes, body, pad);
      if (mode >= 75 && mode < 82) trim_packet($urandom_range(pkt.size(), 1));
    end
  endtask

  task automatic random_packets(input int byte_goal, input int pkt_goal);
    int b0;
    int p0;
    b0 = bytes_sent;
    p0 = packets_sent;
    while (bytes_sent - b0 < byte_goal || packets_sent - p0 < pkt_goal) begin
      make_random_packet();
      send_packet();
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // upper write bits are junk; the registers keep 7 bits
  task automatic set_types(input logic [6:0] audio, input logic [6:0] container);
    logic [31:0] wd;
    logic [31:0] rd;
    drain_results();
    wd = $urandom;
    wd[6:0] = audio;
    apb_access(1'b1, REG_AUDIO_PT, wd, rd);
    sb.audio_pt = audio;
    wd = $urandom;
    wd[6:0] = container;
    apb_access(1'b1, REG_CONTAINER_PT, wd, rd);
    sb.container_pt = container;
    apb_access(1'b0, REG_AUDIO_PT, '0, rd);
    if (rd[6:0] !== audio)
      sb.report($sformatf("audio type read %0d want %0d", rd[6:0], audio));
    apb_access(1'b0, REG_CONTAINER_PT, '0, rd);
    if (rd[6:0] !== container)
      sb.report($sformatf("container type read %0d want %0d", rd[6:0], container));
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_idle_pct = 11;
    out_idle_pct = 85;
    bytes_sent = 0;
    packets_sent = 0;
    stall_cycles = 0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed packets, reset types (audio 10, container 123)
    build_packet(RTP_V2, 0, 0, 0, 7'd10, 0, 0, 0, -1); trim_packet(1); send_packet();
    build_packet(RTP_V2, 0, 0, 0, 7'd127, 0, 0, 0, -1); trim_packet(2); send_packet();
    build_packet(RTP_V2, 0, 0, 0, 7'd10, 0, 0, 0, -1); trim_packet(11); send_packet();
    build_packet(2'd0, 0, 0, 0, 7'd10, 0, 0, 0, -1); send_packet();
    build_packet(2'd1, 0, 0, 0, 7'd10, 0, 0, 0, -1); send_packet();
    build_packet(2'd3, 1, 1, 15, 7'd10, 0, 0, 0, -1); send_packet();
    build_packet(RTP_V2, 0, 0, 0, 7'd10, 0, 0, 0, -1); send_packet();
    build_packet(RTP_V2, 0, 0, 0, 7'd123, 0, 0, 5, -1); send_packet();
    build_packet(RTP_V2, 0, 0, 0, 7'h55, 0, 0, 3, -1); send_packet();
    // CSRC list longer than the packet, then a full one
    build_packet(RTP_V2, 0, 0, 15, 7'd10, 0, 0, 0, -1); trim_packet(71); send_packet();
    build_packet(RTP_V2, 0, 0, 15, 7'd123, 0, 0, 9, -1); send_packet();
    // extension header cut, extension data cut, full extension
    build_packet(RTP_V2, 0, 1, 0, 7'd10, 0, 0, 0, -1); trim_packet(15); send_packet();
    build_packet(RTP_V2, 0, 1, 0, 7'd10, 3, 8, 0, -1); send_packet();
    build_packet(RTP_V2, 0, 1, 2, 7'd10, 16'hFFFF, 4, 6, -1); send_packet();
    build_packet(RTP_V2, 0, 1, 1, 7'd123, 2, 8, 4, -1); send_packet();
    // padding: empty payload, zero octet, too big, exact, large
    build_packet(RTP_V2, 1, 0, 0, 7'd10, 0, 0, 0, -1); send_packet();
    build_packet(RTP_V2, 1, 0, 0, 7'd10, 0, 0, 4, 0); send_packet();
    build_packet(RTP_V2, 1, 0, 0, 7'd10, 0, 0, 4, 5); send_packet();
    build_packet(RTP_V2, 1, 0, 0, 7'd10, 0, 0, 4, 4); send_packet();
    build_packet(RTP_V2, 1, 0, 0, 7'd123, 0, 0, 40, 33); send_packet();

    set_types(7'd0, 7'd127);
    random_packets(60, 2);

    in_idle_pct = 85;
    out_idle_pct = 11;
    set_types(7'd127, 7'd0);
    random_packets(30, 1);
    drain_results();
    random_packets(30, 1);

    in_idle_pct = 0;
    out_idle_pct = 0;
    set_types(7'd77, 7'd77);
    random_packets(15, 1);
    set_types(7'($urandom), 7'($urandom));
    random_packets(40, 2);

    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rtphv_pkg.sv
hw/rtl/rtphv_front.sv
hw/rtl/rtphv_fifo.sv
hw/rtl/rtphv_back.sv
hw/rtl/rtp_header_validator_unit.sv
verif/rtp_header_validator_unit_test.sv
